FILE: src/sync_packet_deframer_checksum_unit_macros.svh
// Assertion macros shared by the deframer RTL modules.
// Each macro expects the including module to have i_clk and i_rst_n in scope.
`ifndef SYNC_PACKET_DEFRAMER_CHECKSUM_UNIT_MACROS_SVH
`define SYNC_PACKET_DEFRAMER_CHECKSUM_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SPDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SPDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/spdc_pkg.sv
// Package for the sync-word packet deframer: sync words, result codes,
// the result record and the sizing of the result queue. No dependencies.
`default_nettype none

package spdc_pkg;

    // Little-endian sync words: low byte received first.
    localparam logic [15:0] SYNC_WITH_SUM = 16'hc1af;
    localparam logic [15:0] SYNC_NO_SUM   = 16'hc1ae;

    // Result kinds.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    // Result queue: must be a power of two and hold at least two entries.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // One result item as it leaves the block.
    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [7:0] packet_type;
        logic [7:0] payload_length;
        logic       had_checksum;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

FILE: src/spdc_core.sv
// Deframer state machine: sync hunt, header capture, payload sum and packet end.
// Depends on spdc_pkg and the assertion macros header.
`default_nettype none

module spdc_core
    import spdc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    output logic [1:0]      o_push_n,
    output t_result         o_res0,
    output t_result         o_res1
);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_TYPE,
        ST_LEN,
        ST_SUM_LO,
        ST_SUM_HI,
        ST_DATA
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_prev, n_prev;
    logic        r_mode, n_mode;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_seen, n_seen;
    logic [15:0] r_exp, n_exp;
    logic [15:0] r_sum, n_sum;

    logic [15:0] w_word;
    logic [15:0] w_sum_add;
    logic [7:0]  w_seen_inc;
    logic [15:0] w_exp_full;

    assign w_word     = {i_byte, r_prev};
    assign w_sum_add  = r_sum + {8'h00, i_byte};
    assign w_seen_inc = r_seen + 8'd1;
    assign w_exp_full = {i_byte, r_exp[7:0]};

    // Next state and the results caused by the byte now presented.
    always_comb begin
        n_state  = r_state;
        n_prev   = r_prev;
        n_mode   = r_mode;
        n_type   = r_type;
        n_len    = r_len;
        n_seen   = r_seen;
        n_exp    = r_exp;
        n_sum    = r_sum;
        o_push_n = 2'd0;
        o_res0   = '0;
        o_res1   = '0;

        unique case (r_state)
            ST_TYPE: begin
                n_type  = i_byte;
                n_state = ST_LEN;
            end
            ST_LEN: begin
                n_len = i_byte;
                if (r_mode) begin
                    n_state = ST_SUM_LO;
                end else begin
                    n_seen = 8'd0;
                    n_sum  = 16'd0;
                    if (i_byte == 8'd0) begin
                        // An empty packet without checksum always ends well.
                        o_push_n              = 2'd1;
                        o_res0.result_kind    = KIND_OK;
                        o_res0.packet_type    = r_type;
                        o_res0.payload_length = i_byte;
                        o_res0.had_checksum   = r_mode;
                        o_res0.last           = 1'b1;
                        n_state               = ST_HUNT;
                        n_prev                = 8'd0;
                    end else begin
                        n_state = ST_DATA;
                    end
                end
            end
            ST_SUM_LO: begin
                n_exp   = {8'h00, i_byte};
                n_state = ST_SUM_HI;
            end
            ST_SUM_HI: begin
                n_exp  = w_exp_full;
                n_seen = 8'd0;
                n_sum  = 16'd0;
                if (r_len == 8'd0) begin
                    // An empty packet checks a sum of zero.
                    o_push_n              = 2'd1;
                    o_res0.result_kind    = (w_exp_full != 16'd0) ? KIND_BAD : KIND_OK;
                    o_res0.packet_type    = r_type;
                    o_res0.payload_length = r_len;
                    o_res0.had_checksum   = r_mode;
                    o_res0.last           = 1'b1;
                    n_state               = ST_HUNT;
                    n_prev                = 8'd0;
                end else begin
                    n_state = ST_DATA;
                end
            end
            ST_DATA: begin
                n_sum                 = w_sum_add;
                n_seen                = w_seen_inc;
                o_res0.result_kind    = KIND_DATA;
                o_res0.payload_byte   = i_byte;
                o_res0.byte_index     = r_seen;
                o_res0.packet_type    = r_type;
                o_res0.payload_length = r_len;
                o_res0.had_checksum   = r_mode;
                if (w_seen_inc == r_len) begin
                    // The final payload byte is followed by the packet end.
                    o_push_n              = 2'd2;
                    o_res0.last           = 1'b0;
                    o_res1.result_kind    = (r_mode && (w_sum_add != r_exp)) ?
                                            KIND_BAD : KIND_OK;
                    o_res1.packet_type    = r_type;
                    o_res1.payload_length = r_len;
                    o_res1.had_checksum   = r_mode;
                    o_res1.last           = 1'b1;
                    n_state               = ST_HUNT;
                    n_prev                = 8'd0;
                end else begin
                    o_push_n    = 2'd1;
                    o_res0.last = 1'b1;
                end
            end
            default: begin
                // Sync hunt over the last two bytes.
                n_prev = i_byte;
                if (w_word == SYNC_WITH_SUM) begin
                    n_mode  = 1'b1;
                    n_state = ST_TYPE;
                    n_prev  = 8'd0;
                end else if (w_word == SYNC_NO_SUM) begin
                    n_mode  = 1'b0;
                    n_state = ST_TYPE;
                    n_prev  = 8'd0;
                end
            end
        endcase
    end

    // Deframer state, advanced once per processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_prev  <= 8'd0;
            r_mode  <= 1'b0;
            r_type  <= 8'd0;
            r_len   <= 8'd0;
            r_seen  <= 8'd0;
            r_exp   <= 16'd0;
            r_sum   <= 16'd0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_prev  <= n_prev;
            r_mode  <= n_mode;
            r_type  <= n_type;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_exp   <= n_exp;
            r_sum   <= n_sum;
        end
    end

    `include "sync_packet_deframer_checksum_unit_macros.svh"

    `SPDC_ASSERT_NEXT(a_pair_ends_packet, i_fire && (o_push_n == 2'd2), r_state == ST_HUNT, "packet end did not return to the hunt")
    `SPDC_ASSERT_NOW(a_pair_last_on_end, o_push_n == 2'd2, o_res1.last && !o_res0.last, "last flag misplaced on a result pair")
    `SPDC_ASSERT_NOW(a_single_is_last, o_push_n == 2'd1, o_res0.last, "single result lacks the last flag")
    `SPDC_ASSERT_NOW(a_prev_clear_off_hunt, r_state != ST_HUNT, r_prev == 8'd0, "previous byte not cleared outside the hunt")

endmodule

`default_nettype wire

FILE: src/spdc_res_fifo.sv
// Small result queue: takes up to two results per cycle, releases one per transaction.
// Depends on spdc_pkg and the assertion macros header.
`default_nettype none

module spdc_res_fifo
    import spdc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_push_n,
    input  wire t_result    i_res0,
    input  wire t_result    i_res1,
    output logic            o_room,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_result         o_res
);

    t_result               r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [RES_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [RES_CNT_W-1:0]  r_count, n_count;
    logic                  w_pop;
    logic [RES_PTR_W-1:0]  w_wr_ptr1;

    assign o_valid   = (r_count != '0);
    assign o_res     = r_mem[r_rd_ptr];
    assign w_pop     = o_valid && i_ready;
    // Room for a worst-case pair of results.
    assign o_room    = (r_count <= RES_CNT_W'(RES_DEPTH - 2));
    assign w_wr_ptr1 = r_wr_ptr + 1'b1;

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wr_ptr = r_wr_ptr + RES_PTR_W'(i_push_n);
        n_rd_ptr = r_rd_ptr + RES_PTR_W'(w_pop);
        n_count  = r_count + RES_CNT_W'(i_push_n) - RES_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Result storage; the first result of a pair goes in first.
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_res1;
        end
    end

    `include "sync_packet_deframer_checksum_unit_macros.svh"

    `SPDC_ASSERT_NOW(a_no_overflow, 1'b1, r_count <= RES_CNT_W'(RES_DEPTH), "result queue count beyond depth")
    `SPDC_ASSERT_NOW(a_push_has_room, i_push_n != 2'd0, o_room, "results pushed without room")
    `SPDC_ASSERT_NEXT(a_pop_only_drains, w_pop && (i_push_n == 2'd0), r_count == $past(r_count) - 1'b1, "pop did not reduce the count")

endmodule

`default_nettype wire

FILE: src/sync_packet_deframer_checksum_unit.sv
// Top level of the sync-word packet deframer with byte-sum checksum.
// Depends on spdc_pkg, spdc_core and spdc_res_fifo.
`default_nettype none

// Accepts one received byte per transaction and one byte per clock cycle when the output
// side keeps up. Each byte is held in an input register, run through the deframer state
// machine once the queue has room, and its zero, one or two results are then registered
// into a four-entry result queue, which offers them on the output port. The single
// result port releases one result per cycle while the receiver is ready; the final payload
// byte of a packet yields two results, which leave one after the other and which the queue
// absorbs. A byte enters the state machine only while the queue has room for two more
// results, so input ready drops while a byte is held and the queue is more than half full.
// No clearing pass follows reset: the block takes bytes as soon as reset is released.
module sync_packet_deframer_checksum_unit
    import spdc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_result_kind,
    output logic [7:0]      o_payload_byte,
    output logic [7:0]      o_byte_index,
    output logic [7:0]      o_packet_type,
    output logic [7:0]      o_payload_length,
    output logic            o_had_checksum,
    output logic            o_last
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       w_room;
    logic       w_fire;
    logic       w_accept;
    logic [1:0] w_push_n;
    t_result    w_res0;
    t_result    w_res1;
    t_result    w_out;

    // The held byte moves on when the queue can take its results.
    assign w_fire     = r_in_vld && w_room;
    assign o_in_ready = !r_in_vld || w_fire;
    assign w_accept   = i_in_valid && o_in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    spdc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_byte   (r_in_byte),
        .o_push_n (w_push_n),
        .o_res0   (w_res0),
        .o_res1   (w_res1)
    );

    spdc_res_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_fire ? w_push_n : 2'd0),
        .i_res0   (w_res0),
        .i_res1   (w_res1),
        .o_room   (w_room),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_res    (w_out)
    );

    // Result fields onto their own ports.
    assign o_result_kind    = w_out.result_kind;
    assign o_payload_byte   = w_out.payload_byte;
    assign o_byte_index     = w_out.byte_index;
    assign o_packet_type    = w_out.packet_type;
    assign o_payload_length = w_out.payload_length;
    assign o_had_checksum   = w_out.had_checksum;
    assign o_last           = w_out.last;

endmodule

`default_nettype wire
